[rtl/bsq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsq_pkg - shared constants and types for the bandwidth sample event queue
// Queue geometry, divider widths, register map and request codes.
// ----------------------------------------------------------------------------
package bsq_pkg;

   // Ring storage geometry
   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;

   // Field widths
   localparam int LEN_W   = 16;
   localparam int TS_W    = 64;
   localparam int WORD_W  = 32;
   localparam int QSIZE_W = 6;

   // Rate math: chunk_length * 1000 fits in 26 bits
   localparam int RATE_SCALE = 1000;
   localparam int DIVIDEND_W = LEN_W + 10;
   localparam int DIVISOR_W  = WORD_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_QUEUE_SIZE = '0;
   localparam logic [QSIZE_W-1:0]    DEFAULT_QSIZE  = QSIZE_W'(8);

   // Request kinds carried on tuser
   localparam logic MODE_FEED = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage : bsq_pkg
`default_nettype wire

[rtl/bsq_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsq_div - radix-2 restoring divider
// Produces one quotient bit per cycle and then raises done.
// ----------------------------------------------------------------------------
module bsq_div
   import bsq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output div_status_type             status,
   output logic [DIVIDEND_W-1:0]      quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Shift in the next dividend bit and try the subtract
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule : bsq_div
`default_nettype wire

[rtl/bandwidth_sample_event_queue_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bandwidth_sample_event_queue_unit - rate sampler with a ring event queue
// Feeds compute bytes-per-second samples and queue them; pops return them.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. A pop goes straight from the idle state
// to the result state; a feed first passes the calc state, and a feed that takes
// a rate sample then waits in the divide state: the rate comes from a radix-2
// divider that retires one quotient bit per cycle over the 26-bit dividend.
// The result moves into the output register once the result side is free,
// and the request side is ready again as soon as it has moved there, so a
// result may wait there while the next request is already being worked on.
// A write to queue_size empties the queue and clears the time base and both
// counters; issue it only while no request is in flight. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module bandwidth_sample_event_queue_unit
   import bsq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [79:0]           req_tdata,   // [15:0] chunk_length, [79:16] timestamp
   input  wire logic [0:0]            req_tuser,   // [0] mode
   // Result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [127:0]               rsp_tdata,   // [31:0] event_offset, [63:32] event_rate,
                                                   // [95:64] sample_count, [127:96] byte_total
   output logic [2:0]                 rsp_tuser,   // [0] status, [1] sample_dropped,
                                                   // [2] event_valid
   // Register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CALC   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [TS_W-1:0]       ts_ff, ts_in;
   logic                  take_ff, take_in;
   logic [QSIZE_W-1:0]    qsize_ff, qsize_in;
   logic [PTR_W-1:0]      rp_ff, rp_in;
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TS_W-1:0]       prev_ff, prev_in;
   logic [WORD_W-1:0]     bytes_ff, bytes_in;
   logic [WORD_W-1:0]     samples_ff, samples_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [127:0]          rsp_data_ff, rsp_data_in;
   logic [2:0]            rsp_user_ff, rsp_user_in;

   // Sample store: {rate, offset}
   logic [63:0]           sample_store_mem [QUEUE_DEPTH];
   logic [63:0]           mem_rd_ff;
   logic                  mem_we;
   logic [63:0]           mem_wdata;

   logic                  req_accept;
   logic                  out_free;
   logic                  cfg_we;
   logic                  commit;
   logic [QSIZE_W-1:0]    depth_sel;
   logic [CNT_W-1:0]      depth;
   logic [TS_W-1:0]       ts_diff;
   logic [DIVISOR_W-1:0]  dt;
   logic [DIVIDEND_W-1:0] dividend;
   logic                  div_start;
   div_status_type        div_stat;
   logic [DIVIDEND_W-1:0] quotient;
   logic [CNT_W-1:0]      rp_inc;
   logic [CNT_W-1:0]      wp_inc;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_DONE) && out_free;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_W-1:2] == REG_QUEUE_SIZE);

   // Ring depth in use: zero picks the default, clamp at the storage depth
   assign depth_sel = (qsize_ff == '0) ? DEFAULT_QSIZE : qsize_ff;
   assign depth     = (32'(depth_sel) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH)
                                                     : CNT_W'(depth_sel);
   assign rp_inc    = CNT_W'(rp_ff) + 1'b1;
   assign wp_inc    = CNT_W'(wp_ff) + 1'b1;

   // Time step: low 32 bits of the advance, else one; zero becomes one
   assign ts_diff  = ts_ff - prev_ff;
   always_comb begin
      dt = (ts_ff > prev_ff) ? ts_diff[DIVISOR_W-1:0] : DIVISOR_W'(1);
      if (dt == '0) begin
         dt = DIVISOR_W'(1);
      end
   end
   assign dividend = DIVIDEND_W'(len_ff) * DIVIDEND_W'(RATE_SCALE);

   bsq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (dt),
      .status   (div_stat),
      .quotient (quotient)
   );

   // Sequencer and queue bookkeeping
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      ts_in        = ts_ff;
      take_in      = take_ff;
      qsize_in     = qsize_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      bytes_in     = bytes_ff;
      samples_in   = samples_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_start    = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = {WORD_W'(quotient), bytes_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in  = req_tuser[0];
               len_in   = req_tdata[LEN_W-1:0];
               ts_in    = req_tdata[LEN_W+TS_W-1:LEN_W];
               take_in  = 1'b0;
               state_in = (req_tuser[0] == MODE_POP) ? ST_DONE : ST_CALC;
            end
         end
         ST_CALC: begin
            // Start a rate sample when the length is nonzero and both timestamps are present
            if (len_ff != '0 && ts_ff != '0 && prev_ff != '0) begin
               take_in   = 1'b1;
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in  = ST_DONE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_user_in  = '0;
               rsp_data_in  = '0;
               if (mode_ff == MODE_POP) begin
                  // Pop the oldest entry when there is one
                  if (count_ff != '0) begin
                     rsp_user_in[2]     = 1'b1;
                     rsp_data_in[63:0]  = mem_rd_ff;
                     rp_in              = (rp_inc == depth) ? '0 : rp_inc[PTR_W-1:0];
                     count_in           = count_ff - 1'b1;
                  end
               end else if (len_ff == '0) begin
                  rsp_user_in[0] = 1'b1;
               end else begin
                  if (take_ff) begin
                     // Push or drop, and count the sample either way
                     if (count_ff >= depth) begin
                        rsp_user_in[1] = 1'b1;
                     end else begin
                        mem_we   = 1'b1;
                        wp_in    = (wp_inc == depth) ? '0 : wp_inc[PTR_W-1:0];
                        count_in = count_ff + 1'b1;
                     end
                     samples_in = samples_ff + 1'b1;
                     bytes_in   = bytes_ff + WORD_W'(len_ff);
                  end
                  if (ts_ff != '0) begin
                     prev_in = ts_ff;
                  end
               end
               rsp_data_in[95:64]  = samples_in;
               rsp_data_in[127:96] = bytes_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register write reinitializes the run state
      if (cfg_we) begin
         qsize_in   = csr_pwdata[QSIZE_W-1:0];
         rp_in      = '0;
         wp_in      = '0;
         count_in   = '0;
         prev_in    = '0;
         bytes_in   = '0;
         samples_in = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         take_ff      <= 1'b0;
         qsize_ff     <= DEFAULT_QSIZE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         count_ff     <= '0;
         prev_ff      <= '0;
         bytes_ff     <= '0;
         samples_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         take_ff      <= take_in;
         qsize_ff     <= qsize_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         bytes_ff     <= bytes_in;
         samples_ff   <= samples_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      len_ff      <= len_in;
      ts_ff       <= ts_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Sample store, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_store_mem[wp_ff] <= mem_wdata;
      end
      mem_rd_ff <= sample_store_mem[rp_ff];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Register read-back
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_QUEUE_SIZE) ?
                       CSR_DATA_W'(qsize_ff) : '0;

   // Fill level never passes the depth in use
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= depth)
      else $error("entry count above ring depth");

   // Pointers stay inside the ring
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(rp_ff) < depth) && (CNT_W'(wp_ff) < depth))
      else $error("queue pointer outside ring");

   // Divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // Divider is quiet whenever a new request may enter
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider busy while idle");

   // A pop of a nonempty queue removes exactly one entry
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (commit && mode_ff == MODE_POP && count_ff != '0 && !cfg_we)
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not remove one entry");

endmodule : bandwidth_sample_event_queue_unit
`default_nettype wire

[sim/bandwidth_sample_event_queue_unit_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bandwidth_sample_event_queue_unit_tb - self-checking bench for the rate queue
// Drives feed and pop beats with random gaps and result stalls, predicts every
// result beat, and compares all fields. Covers zero-length and timestamp-less
// feeds, non-advancing and 32-bit-wrapping time, full-queue drops, empty pops
// and a range of queue_size settings including zero and values past the depth.
// ----------------------------------------------------------------------------
module bandwidth_sample_event_queue_unit_tb;
   import bsq_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 156;
   localparam int CALM_ITEMS    = 150;
   localparam logic [CSR_ADDR_W-1:0] ADDR_QSIZE = {REG_QUEUE_SIZE, 2'b00};
   // register index one: not mapped, writes must be ignored
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = CSR_ADDR_W'(4);

   typedef struct packed {
      logic              status;
      logic              dropped;
      logic              valid;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] rate;
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] total;
   } sample_result_type;

   // Rate sampler shadow: ring, pointers, time base, counters, expected beats
   class sample_queue_checker;
      bit [2*WORD_W-1:0] ring [QUEUE_DEPTH];
      int unsigned       rd_idx, wr_idx, fill;
      bit [TS_W-1:0]     last_stamp;
      bit [WORD_W-1:0]   byte_sum, sample_sum;
      bit [QSIZE_W-1:0]  qsize;
      sample_result_type pending [$];
      int                errors, samples_taken, drops, pops_hit, pops_empty, rejects;
      int                requests;

      function new();
         qsize = DEFAULT_QSIZE;
         restart();
      endfunction

      function void restart();
         rd_idx     = 0;
         wr_idx     = 0;
         fill       = 0;
         last_stamp = '0;
         byte_sum   = '0;
         sample_sum = '0;
      endfunction

      function void set_queue_size(bit [CSR_DATA_W-1:0] value);
         qsize = value[QSIZE_W-1:0];
         restart();
      endfunction

      function int unsigned depth_in_use();
         if (qsize == 0) return DEFAULT_QSIZE;
         if (qsize > QUEUE_DEPTH) return QUEUE_DEPTH;
         return qsize;
      endfunction

      // Predict the result of one accepted request beat
      function void take_request(bit mode, bit [LEN_W-1:0] len, bit [TS_W-1:0] stamp);
         sample_result_type r;
         int unsigned       depth;
         bit [WORD_W-1:0]   dt, bps;
         bit [2*WORD_W-1:0] entry;
         r     = '0;
         depth = depth_in_use();
         requests++;
         if (mode == MODE_POP) begin
            if (fill > 0) begin
               entry    = ring[rd_idx % depth];
               r.valid  = 1'b1;
               r.offset = entry[WORD_W-1:0];
               r.rate   = entry[2*WORD_W-1:WORD_W];
               rd_idx   = (rd_idx % depth + 1) % depth;
               fill--;
               pops_hit++;
            end else begin
               pops_empty++;
            end
         end else if (len == 0) begin
            r.status = 1'b1;
            rejects++;
         end else begin
            if (stamp != 0 && last_stamp != 0) begin
               dt = (stamp > last_stamp) ? WORD_W'(stamp - last_stamp) : WORD_W'(1);
               if (dt == 0) dt = 1;
               bps = (WORD_W'(len) * WORD_W'(RATE_SCALE)) / dt;
               if (fill >= depth) begin
                  r.dropped = 1'b1;
                  drops++;
               end else begin
                  ring[wr_idx % depth] = {bps, byte_sum};
                  wr_idx = (wr_idx % depth + 1) % depth;
                  fill++;
               end
               sample_sum++;
               byte_sum += WORD_W'(len);
               samples_taken++;
            end
            if (stamp != 0) last_stamp = stamp;
         end
         r.count = sample_sum;
         r.total = byte_sum;
         pending.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] MISMATCH %s", $time, what);
      endtask

      // Compare one result beat with the oldest prediction
      task compare_result(sample_result_type got);
         sample_result_type exp;
         if (pending.size() == 0) begin
            report_mismatch("result beat with no request outstanding");
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status)
            report_mismatch($sformatf("status got %b want %b", got.status, exp.status));
         if (got.dropped !== exp.dropped)
            report_mismatch($sformatf("sample_dropped got %b want %b", got.dropped,
                                      exp.dropped));
         if (got.valid !== exp.valid)
            report_mismatch($sformatf("event_valid got %b want %b", got.valid, exp.valid));
         if (got.offset !== exp.offset)
            report_mismatch($sformatf("event_offset got %h want %h", got.offset, exp.offset));
         if (got.rate !== exp.rate)
            report_mismatch($sformatf("event_rate got %h want %h", got.rate, exp.rate));
         if (got.count !== exp.count)
            report_mismatch($sformatf("sample_count got %h want %h", got.count, exp.count));
         if (got.total !== exp.total)
            report_mismatch($sformatf("byte_total got %h want %h", got.total, exp.total));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [LEN_W+TS_W-1:0]     req_tdata;    // [15:0] chunk_length, [79:16] timestamp
   logic [0:0]                req_tuser;    // [0] mode
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [4*WORD_W-1:0]       rsp_tdata;    // [31:0] offset, [63:32] rate,
                                            // [95:64] sample_count, [127:96] byte_total
   logic [2:0]                rsp_tuser;    // [0] status, [1] sample_dropped, [2] event_valid
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_W-1:0]     csr_paddr;
   logic [CSR_DATA_W-1:0]     csr_pwdata;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   sample_queue_checker sb;
   bit                  calm;
   int                  gap_odds, stall_odds, hold_left;
   int                  cycles;
   int                  settings_used;
   bit [TS_W-1:0]       stamp_base;

   bandwidth_sample_event_queue_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  sb.pending.size());
         $display("** bandwidth_sample_event_queue_unit: FAILED **");
         $finish;
      end
   end

   // Check result beats and stall the result side in random bursts
   always @(posedge clock) begin
      sample_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status  = rsp_tuser[0];
         got.dropped = rsp_tuser[1];
         got.valid   = rsp_tuser[2];
         got.offset  = rsp_tdata[WORD_W-1:0];
         got.rate    = rsp_tdata[2*WORD_W-1:WORD_W];
         got.count   = rsp_tdata[3*WORD_W-1:2*WORD_W];
         got.total   = rsp_tdata[4*WORD_W-1:3*WORD_W];
         sb.compare_result(got);
      end
      if (calm || stall_odds == 0) begin
         hold_left = 0;
         rsp_tready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(1, stall_odds) == 1) begin
         hold_left = $urandom_range(1, 15) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Send one request beat, optionally after an idle burst, and wait for it
   task automatic send_item(bit mode, bit [LEN_W-1:0] len, bit [TS_W-1:0] stamp);
      int gap;
      gap = 0;
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
         gap = $urandom_range(1, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= mode;
      req_tdata    <= {stamp, len};
      do @(posedge clock); while (!req_tready);
      sb.take_request(mode, len, stamp);
   endtask

   // Hold off the sender until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_QSIZE) sb.set_queue_size(data);
   endtask

   task automatic csr_check_qsize();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_QSIZE;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(sb.qsize))
         sb.report_mismatch($sformatf("queue_size read %h want %h", csr_prdata, sb.qsize));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Boundary cases under the reset queue size of eight
   task automatic directed_pass();
      send_item(MODE_POP,  16'hFFFF, '1);            // pop on empty queue
      send_item(MODE_FEED, 16'd0, 64'd5);            // zero length rejected
      send_item(MODE_FEED, 16'd100, 64'd0);          // no timestamp, no time base yet
      send_item(MODE_FEED, 16'hFFFF, 64'd1000);      // first timestamp: no sample
      send_item(MODE_FEED, 16'hFFFF, 64'd1000);      // time did not advance
      send_item(MODE_FEED, 16'd1, 64'd0);            // no timestamp keeps time base
      send_item(MODE_FEED, 16'd500, 64'd1250);
      send_item(MODE_FEED, 16'd1234, 64'd999);       // time went backward
      send_item(MODE_FEED, 16'd7, 64'd999 + (64'd1 << 32)); // dt wraps to zero
      send_item(MODE_FEED, 16'hFFFF, '1);            // largest timestamp
      send_item(MODE_FEED, 16'd0, 64'd0);
      send_item(MODE_FEED, 16'd8, 64'd2);
      send_item(MODE_FEED, 16'd16, 64'd3);
      send_item(MODE_FEED, 16'd32, 64'd4);           // queue now full
      send_item(MODE_FEED, 16'd1, 64'd4);            // dropped
      repeat (9) send_item(MODE_POP, '1, '1);        // empty it and pop once more
   endtask

   // One random request: feeds walk forward in time with occasional oddities
   task automatic random_item(int pop_pct);
      bit [LEN_W-1:0] len;
      bit [TS_W-1:0]  stamp;
      if ($urandom_range(0, 99) < pop_pct) begin
         send_item(MODE_POP, LEN_W'($urandom), {$urandom, $urandom});
         return;
      end
      case ($urandom_range(0, 9))
         0:       len = '0;
         1:       len = '1;
         2:       len = LEN_W'($urandom_range(1, 64));
         default: len = LEN_W'($urandom);
      endcase
      case ($urandom_range(0, 19))
         0:       stamp = '0;
         1:       stamp = {$urandom, $urandom};
         2:       stamp = stamp_base - TS_W'($urandom_range(1, 500));
         3:       stamp = stamp_base + (TS_W'($urandom_range(1, 3)) << 32)
                          + TS_W'($urandom_range(0, 3));
         4:       stamp = stamp_base;
         default: stamp = stamp_base + TS_W'($urandom_range(1, 2000));
      endcase
      if (stamp != 0) stamp_base = stamp;
      send_item(MODE_FEED, len, stamp);
   endtask

   function automatic int pick_odds();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 8;
      endcase
   endfunction

   initial begin
      bit [QSIZE_W-1:0] phase_qsize [PHASES];
      int               pop_pct;
      sb            = new();
      phase_qsize   = '{1, 0, 32, 63, 33, 2, 0, 5};
      phase_qsize[6] = QSIZE_W'($urandom_range(3, 31));
      calm          = 1'b0;
      gap_odds      = 4;
      stall_odds    = 4;
      settings_used = 1;
      stamp_base    = 64'd5000;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed_pass();

      // Random phases, each under a fresh queue_size from an idle block
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         if (ph == 3) csr_write(ADDR_SPARE, $urandom);
         csr_write(ADDR_QSIZE, {$urandom, phase_qsize[ph]} >> 0 & {{(CSR_DATA_W-QSIZE_W){1'b1}},
                   {QSIZE_W{1'b1}}} & ({$urandom} << QSIZE_W | CSR_DATA_W'(phase_qsize[ph])));
         csr_check_qsize();
         settings_used++;
         stamp_base = 64'd5000 + TS_W'($urandom_range(0, 1000));
         gap_odds   = pick_odds();
         stall_odds = pick_odds();
         pop_pct    = $urandom_range(25, 55);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == PHASES - 1 && i == PHASE_ITEMS - CALM_ITEMS) calm = 1'b1;
            random_item(pop_pct);
         end
      end

      drain_results();
      $display("covered %0d requests over %0d queue settings: %0d samples, %0d dropped",
               sb.requests, settings_used, sb.samples_taken, sb.drops);
      $display("%0d pops returned entries, %0d found the queue empty, %0d feeds rejected",
               sb.pops_hit, sb.pops_empty, sb.rejects);
      if (sb.errors == 0)
         $display("** bandwidth_sample_event_queue_unit: PASSED **");
      else
         $display("** bandwidth_sample_event_queue_unit: FAILED **");
      $finish;
   end

endmodule : bandwidth_sample_event_queue_unit_tb
`default_nettype wire
